// ===== rtl/bffsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bffsc_pkg
// Shared types and constants of the allocation bitmap with find-first-set and
// find-first-clear searches.
// ----------------------------------------------------------------------------
package bffsc_pkg;

	localparam int CMD_W       = 3;
	localparam int POS_W       = 10;
	localparam int BIT_COUNT_W = 11;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// request codes
	localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_ONE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND_ZERO = 3'd5;

	// register index, taken from paddr[2]
	localparam logic REG_BIT_COUNT = 1'b0;

	localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RESET = 11'd1024;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] bit_index;
	} req_item_t;

	typedef struct packed {
		logic             status;
		logic             bit_value;
		logic [POS_W-1:0] position;
	} rsp_item_t;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_LOC  = 6'b000100,
		S_MOD  = 6'b001000,
		S_SCAN = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

// ===== rtl/bffsc_store.sv =====
// ----------------------------------------------------------------------------
// bffsc_store
// Word store of the bitmap: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bffsc_store #(
	parameter int WORD_BITS = 32,
	parameter int NUM_WORDS = 32,
	parameter int AW        = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bffsc_find.sv =====
// ----------------------------------------------------------------------------
// bffsc_find
// Lowest bit of one word that equals the wanted value, limited to the bits
// that still lie below the bit count.
// ----------------------------------------------------------------------------
module bffsc_find #(
	parameter int WORD_BITS = 32,
	parameter int CW        = 11,
	parameter int OW        = 5
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic                 want,
	input  logic [CW-1:0]        rem,
	output logic                 hit,
	output logic [OW-1:0]        off
);

	logic [WORD_BITS-1:0] cand;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			cand[j] = (word[j] == want) && (rem > CW'(j));
		end
	end

	// priority encoder, lowest candidate wins
	always_comb begin
		off = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				off = OW'(j);
			end
		end
	end

	assign hit = |cand;

endmodule

// ===== rtl/bitmap_find_first_set_clear_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_find_first_set_clear_top
// Allocation bitmap with get, set, clear, clear all and find-first searches.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/stall) and each gives exactly one item on rsp.
// The user writes the bit count in use over the APB port at address 0 only
// while idle; the block itself does not enforce this. The map sits in a word
// memory of NUM_WORDS words with registered reads; one request is worked on
// at a time, so a read-modify-write always finishes before the next request
// can read the same word. Get/set/clear walk the word counter to the word of
// bit_index; find first one/zero scans one word per cycle and clear all
// writes one word per cycle; an index out of range, an unused code or a find
// with a zero count goes straight to the done state.
// After reset a sweep zeroes the memory word by word; req is stalled during
// it while configuration writes are taken as ever.
// The result sits in an output register; a stalled rsp holds its item and a
// new request is still accepted and worked on, waiting only to hand over its
// own result until the register is free.
// ----------------------------------------------------------------------------
module bitmap_find_first_set_clear_top #(
	parameter int MAX_BITS  = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bffsc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [bffsc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bffsc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  bffsc_pkg::req_item_t                req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output bffsc_pkg::rsp_item_t                rsp
);

	import bffsc_pkg::*;

	localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OW        = $clog2(WORD_BITS);
	localparam int BASE_W    = $clog2(MAX_BITS + 2 * WORD_BITS);
	localparam int CW        = (BASE_W > BIT_COUNT_W) ? BASE_W : BIT_COUNT_W;

	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BITS);
	localparam logic [CW-1:0] WB_CNT    = CW'(WORD_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

	state_t                   state_q;
	logic [BIT_COUNT_W-1:0]   bit_count_q;
	logic [CMD_W-1:0]         cmd_q;
	logic [POS_W-1:0]         idx_q;
	logic [AW-1:0]            word_q;
	logic [CW-1:0]            base_q;
	logic [CW-1:0]            dbase_s1;
	logic                     dvalid_s1;
	logic                     clr_reply_q;
	rsp_item_t                res_q;
	rsp_item_t                rsp_q;
	logic                     rsp_valid_q;

	logic [CW-1:0]            eff_cnt;
	logic [CW-1:0]            bc_ext;
	logic [CW-1:0]            req_idx_ext;
	logic [CW-1:0]            idx_ext;
	logic                     req_oor;
	logic                     in_word;
	logic                     scan_issue;
	logic [OW-1:0]            off;
	logic [CW-1:0]            rem;
	logic                     last_word;
	logic                     want;
	logic                     hit;
	logic [OW-1:0]            hit_off;
	logic [CW-1:0]            found_pos;

	logic                     mem_we;
	logic [WORD_BITS-1:0]     mem_wdata;
	logic                     mem_re;
	logic [WORD_BITS-1:0]     rd_data;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= BIT_COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_COUNT)) begin
			bit_count_q <= pwdata[BIT_COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BIT_COUNT) begin
			prdata = APB_DATA_W'(bit_count_q);
		end
	end

	// count in use saturates at the map size
	assign bc_ext      = CW'(bit_count_q);
	assign eff_cnt     = (bc_ext > MAX_CNT) ? MAX_CNT : bc_ext;
	assign req_idx_ext = CW'(req.bit_index);
	assign idx_ext     = CW'(idx_q);
	assign req_oor     = req_idx_ext >= eff_cnt;

	assign in_word    = idx_ext < (base_q + WB_CNT);
	assign scan_issue = (state_q == S_SCAN) && (base_q < eff_cnt);
	assign off        = OW'(idx_ext - base_q);

	// scan evaluation of the word read in the previous cycle
	assign rem       = (eff_cnt > dbase_s1) ? (eff_cnt - dbase_s1) : '0;
	assign last_word = (dbase_s1 + WB_CNT) >= eff_cnt;
	assign want      = (cmd_q != CMD_FIND_ZERO);
	assign found_pos = dbase_s1 + CW'(hit_off);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_LOC: begin
				mem_re = in_word;
			end
			S_SCAN: begin
				mem_re = scan_issue;
			end
			S_MOD: begin
				mem_wdata      = rd_data;
				mem_wdata[off] = (cmd_q == CMD_SET);
				mem_we         = (cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR);
			end
			S_IDLE, S_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bffsc_store #(
		.WORD_BITS (WORD_BITS),
		.NUM_WORDS (NUM_WORDS),
		.AW        (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (word_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (word_q),
		.rdata (rd_data)
	);

	bffsc_find #(
		.WORD_BITS (WORD_BITS),
		.CW        (CW),
		.OW        (OW)
	) u_find (
		.word (rd_data),
		.want (want),
		.rem  (rem),
		.hit  (hit),
		.off  (hit_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cmd_q       <= CMD_GET;
			idx_q       <= '0;
			word_q      <= '0;
			base_q      <= '0;
			dbase_s1    <= '0;
			dvalid_s1   <= 1'b0;
			clr_reply_q <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the done state reloads the register itself
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (word_q == LAST_WORD) begin
						word_q <= '0;
						if (clr_reply_q) begin
							clr_reply_q <= 1'b0;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						word_q <= word_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q           <= req.cmd;
						idx_q           <= req.bit_index;
						word_q          <= '0;
						base_q          <= '0;
						dvalid_s1       <= 1'b0;
						res_q.bit_value <= 1'b0;
						res_q.position  <= '0;
						priority case (req.cmd)
							CMD_GET, CMD_SET, CMD_CLEAR: begin
								if (req_oor) begin
									res_q.status <= 1'b1;
									state_q      <= S_DONE;
								end else begin
									res_q.status <= 1'b0;
									state_q      <= S_LOC;
								end
							end
							CMD_CLEAR_ALL: begin
								res_q.status <= 1'b0;
								clr_reply_q  <= 1'b1;
								state_q      <= S_CLR;
							end
							CMD_FIND_ONE, CMD_FIND_ZERO: begin
								if (eff_cnt == '0) begin
									res_q.status <= 1'b1;
									state_q      <= S_DONE;
								end else begin
									res_q.status <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							default: begin
								res_q.status <= 1'b1;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_LOC: begin
					if (in_word) begin
						state_q <= S_MOD;
					end else begin
						word_q <= word_q + 1'b1;
						base_q <= base_q + WB_CNT;
					end
				end
				S_MOD: begin
					if (cmd_q == CMD_GET) begin
						res_q.bit_value <= rd_data[off];
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					dvalid_s1 <= scan_issue;
					dbase_s1  <= base_q;
					if (scan_issue) begin
						word_q <= word_q + 1'b1;
						base_q <= base_q + WB_CNT;
					end
					if (dvalid_s1) begin
						if (hit) begin
							res_q.position <= found_pos[POS_W-1:0];
							state_q        <= S_DONE;
						end else if (last_word) begin
							res_q.status <= 1'b1;
							state_q      <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the memory is written only by the sweep or a set/clear update
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLR || state_q == S_MOD))
		else $error("bitmap word written outside sweep or update");

	// an update never reaches a word for an index beyond the count
	a_mod_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |-> (idx_ext < eff_cnt))
		else $error("update of an index beyond the bit count");

	// a new result only comes out of the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_DONE))
		else $error("result item raised outside done state");

	// the scan never evaluates a word at or above the count
	a_scan_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && dvalid_s1) |-> (dbase_s1 < eff_cnt))
		else $error("scan evaluated a word beyond the bit count");

endmodule
